>>> hw/rtl/dual_channel_wave_table_generator_top_assert.svh
// Assertion macros for the dual channel wave table generator.
// Used by the modules that check their own logic; needs nothing else.
`ifndef DUAL_CHANNEL_WAVE_TABLE_GENERATOR_TOP_ASSERT_SVH
`define DUAL_CHANNEL_WAVE_TABLE_GENERATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define DCWG_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define DCWG_CHECK_IMPLY(lbl, cond, conseq, msg) \
  `DCWG_CHECK(lbl, (cond) |-> (conseq), msg)

`else

`define DCWG_CHECK(lbl, prop, msg)
`define DCWG_CHECK_IMPLY(lbl, cond, conseq, msg)

`endif

`endif

>>> hw/rtl/dcwg_pkg.sv
// Shared constants, codes and the sine ROM of the wave table generator.
// No dependencies; every RTL module refers to it by scoped names.
package dcwg_pkg;

  // Default values of the top level parameters
  localparam int LUT_DEPTH_DEF   = 256;
  localparam int AMP_STEPS_DEF   = 10;
  localparam int FREQ_STEPS_DEF  = 10;
  localparam int DELAY_STEPS_DEF = 8;
  localparam int MAX_FREQ_HZ_DEF = 1000;

  // Field widths
  localparam int PHASE_W  = 8;
  localparam int KNOB_W   = 3;
  localparam int SAMPLE_W = 12;
  localparam int FREQ_W   = 10;
  localparam int MV_W     = 12;
  localparam int PCT_W    = 7;
  localparam int OFFSET_W = 12;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 80;

  // Wave ROM geometry and levels
  localparam int ROM_AW      = 8;
  localparam int ROM_SIZE    = 256;
  localparam int WAVE_PEAK   = 3996;
  localparam int SQUARE_HIGH = 128;
  localparam int PULSE_HIGH  = 26;

  // Scaling constants
  localparam int FULL_MV      = 3300;
  localparam int PCT_FULL     = 100;
  localparam int SAMPLE_MAX   = 4095;
  localparam int MV_MAX       = 4095;
  localparam int FREQ_MAX_OUT = 1023;

  // Fraction bits of the reciprocal multipliers
  localparam int AMP_FRAC  = 24;
  localparam int ADDR_FRAC = 32;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_PULSE  = 2'd2
  } wave_t;

  typedef enum logic [KNOB_W-1:0] {
    KNOB_TYPE   = 3'd0,
    KNOB_AMP    = 3'd1,
    KNOB_FREQ   = 3'd2,
    KNOB_FOLLOW = 3'd3,
    KNOB_DELAY  = 3'd4
  } knob_t;

  // One period of sine, centered on 1998, peak 3996
  localparam logic [SAMPLE_W-1:0] SINE_ROM [ROM_SIZE] = '{
    12'd1998, 12'd2047, 12'd2096, 12'd2144, 12'd2193, 12'd2242, 12'd2291, 12'd2339,
    12'd2387, 12'd2435, 12'd2483, 12'd2530, 12'd2577, 12'd2624, 12'd2671, 12'd2717,
    12'd2762, 12'd2807, 12'd2852, 12'd2896, 12'd2939, 12'd2982, 12'd3025, 12'd3066,
    12'd3108, 12'd3148, 12'd3188, 12'd3227, 12'd3265, 12'd3303, 12'd3339, 12'd3375,
    12'd3410, 12'd3445, 12'd3478, 12'd3510, 12'd3542, 12'd3573, 12'd3602, 12'd3631,
    12'd3659, 12'd3686, 12'd3711, 12'd3736, 12'd3760, 12'd3782, 12'd3804, 12'd3824,
    12'd3843, 12'd3862, 12'd3879, 12'd3895, 12'd3909, 12'd3923, 12'd3936, 12'd3947,
    12'd3957, 12'd3966, 12'd3974, 12'd3980, 12'd3986, 12'd3990, 12'd3993, 12'd3995,
    12'd3996, 12'd3995, 12'd3993, 12'd3990, 12'd3986, 12'd3980, 12'd3974, 12'd3966,
    12'd3957, 12'd3947, 12'd3936, 12'd3923, 12'd3909, 12'd3895, 12'd3879, 12'd3862,
    12'd3843, 12'd3824, 12'd3804, 12'd3782, 12'd3760, 12'd3736, 12'd3711, 12'd3686,
    12'd3659, 12'd3631, 12'd3602, 12'd3573, 12'd3542, 12'd3510, 12'd3478, 12'd3445,
    12'd3410, 12'd3375, 12'd3339, 12'd3303, 12'd3265, 12'd3227, 12'd3188, 12'd3148,
    12'd3108, 12'd3066, 12'd3025, 12'd2982, 12'd2939, 12'd2896, 12'd2852, 12'd2807,
    12'd2762, 12'd2717, 12'd2671, 12'd2624, 12'd2577, 12'd2530, 12'd2483, 12'd2435,
    12'd2387, 12'd2339, 12'd2291, 12'd2242, 12'd2193, 12'd2144, 12'd2096, 12'd2047,
    12'd1998, 12'd1948, 12'd1899, 12'd1851, 12'd1802, 12'd1753, 12'd1704, 12'd1656,
    12'd1608, 12'd1560, 12'd1512, 12'd1465, 12'd1418, 12'd1371, 12'd1324, 12'd1278,
    12'd1233, 12'd1188, 12'd1143, 12'd1099, 12'd1056, 12'd1013, 12'd970,  12'd929,
    12'd887,  12'd847,  12'd807,  12'd768,  12'd730,  12'd692,  12'd656,  12'd620,
    12'd585,  12'd550,  12'd517,  12'd485,  12'd453,  12'd422,  12'd393,  12'd364,
    12'd336,  12'd309,  12'd284,  12'd259,  12'd235,  12'd213,  12'd191,  12'd171,
    12'd152,  12'd133,  12'd116,  12'd100,  12'd86,   12'd72,   12'd59,   12'd48,
    12'd38,   12'd29,   12'd21,   12'd15,   12'd9,    12'd5,    12'd2,    12'd0,
    12'd0,    12'd0,    12'd2,    12'd5,    12'd9,    12'd15,   12'd21,   12'd29,
    12'd38,   12'd48,   12'd59,   12'd72,   12'd86,   12'd100,  12'd116,  12'd133,
    12'd152,  12'd171,  12'd191,  12'd213,  12'd235,  12'd259,  12'd284,  12'd309,
    12'd336,  12'd364,  12'd393,  12'd422,  12'd453,  12'd485,  12'd517,  12'd550,
    12'd585,  12'd620,  12'd656,  12'd692,  12'd730,  12'd768,  12'd807,  12'd847,
    12'd887,  12'd929,  12'd970,  12'd1013, 12'd1056, 12'd1099, 12'd1143, 12'd1188,
    12'd1233, 12'd1278, 12'd1324, 12'd1371, 12'd1418, 12'd1465, 12'd1512, 12'd1560,
    12'd1608, 12'd1656, 12'd1704, 12'd1753, 12'd1802, 12'd1851, 12'd1899, 12'd1948
  };

endpackage

>>> hw/rtl/dual_channel_wave_table_generator_top.sv
// Top level of the dual channel wave table generator: stream ports, offset
// register and three pipeline registers. Uses dcwg_pkg, dcwg_knobs,
// dcwg_addr, dcwg_voice and the assertion header.
//
//  port group | dir | payload
//  -----------+-----+---------------------------------------------------
//  s_*        | in  | tuser: mode; tdata: channel, knob, direction, phase
//  m_*        | out | tdata: samples, Hz, mV, types, delay %, follow
//  cfg_*      | in  | vertical offset, written when cfg_we is high
//
// One item per clock cycle while no stage stalls. A result shows on m_tvalid after
// the item passes the input register, address register and result register.
// The address stage does one ROM address multiply, the result stage one
// amplitude multiply per channel.
// Reset clears the knob state to its defaults, the offset to zero and all
// valid flags; no memory needs a clearing pass.
// Each stage holds only while the stage after it is full and stalled, so
// items are still accepted while a result waits if a stage is empty.
`include "dual_channel_wave_table_generator_top_assert.svh"

module dual_channel_wave_table_generator_top #(
  parameter int LUT_DEPTH   = dcwg_pkg::LUT_DEPTH_DEF,
  parameter int AMP_STEPS   = dcwg_pkg::AMP_STEPS_DEF,
  parameter int FREQ_STEPS  = dcwg_pkg::FREQ_STEPS_DEF,
  parameter int DELAY_STEPS = dcwg_pkg::DELAY_STEPS_DEF,
  parameter int MAX_FREQ_HZ = dcwg_pkg::MAX_FREQ_HZ_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dcwg_pkg::OFFSET_W-1:0] cfg_wdata,  // vertical_offset
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dcwg_pkg::IN_W-1:0]     s_tdata,    // channel, knob, direction, phase_index
  input  logic                          s_tuser,    // mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // sample_one, sample_two, freq_hz_one, freq_hz_two, amp_mv_one, amp_mv_two,
  // type_one, type_two, delay_percent, follow_on
  output logic [dcwg_pkg::OUT_W-1:0]    m_tdata
);

  localparam int AW = $clog2(AMP_STEPS + 1);
  localparam int FW = $clog2(FREQ_STEPS + 1);
  localparam int DW = $clog2(DELAY_STEPS + 1);
  localparam longint unsigned AM_RECIP =
    ((64'd1 << dcwg_pkg::AMP_FRAC) + AMP_STEPS - 1) / AMP_STEPS;
  localparam int MULW = $clog2(AMP_STEPS * AM_RECIP + 1);

  // Input field positions in s_tdata
  localparam int CH_LSB    = 0;
  localparam int KNOB_LSB  = CH_LSB + 1;
  localparam int DIR_LSB   = KNOB_LSB + dcwg_pkg::KNOB_W;
  localparam int PHASE_LSB = DIR_LSB + 1;

  localparam int RA = dcwg_pkg::ROM_AW;
  localparam int HW = dcwg_pkg::FREQ_W;
  localparam int MW = dcwg_pkg::MV_W;
  localparam int CW = dcwg_pkg::PCT_W;
  localparam int SW = dcwg_pkg::SAMPLE_W;

  // Handshake
  logic accept;
  logic ready_two;
  logic ready_out;

  // Offset register
  logic [dcwg_pkg::OFFSET_W-1:0] vertical_offset;

  // Knob state
  dcwg_pkg::wave_t kind   [2];
  logic [AW-1:0]   amp    [2];
  logic [FW-1:0]   freq   [2];
  logic [DW-1:0]   delay;
  logic            follow;

  // Input register
  logic                         in_valid;
  logic [dcwg_pkg::PHASE_W-1:0] in_phase;

  // Address stage outputs
  logic [RA-1:0]   a_addr_one;
  logic [RA-1:0]   a_addr_two;
  dcwg_pkg::wave_t a_kind_two;
  logic [MULW-1:0] a_amul_one;
  logic [MULW-1:0] a_amul_two;
  logic [HW-1:0]   a_hz_one;
  logic [HW-1:0]   a_hz_two;
  logic [MW-1:0]   a_mv_one;
  logic [MW-1:0]   a_mv_two;
  logic [CW-1:0]   a_pct;

  // Address register
  logic            st_valid;
  logic [RA-1:0]   st_addr_one;
  logic [RA-1:0]   st_addr_two;
  dcwg_pkg::wave_t st_kind_one;
  dcwg_pkg::wave_t st_kind_two;
  logic [MULW-1:0] st_amul_one;
  logic [MULW-1:0] st_amul_two;
  logic [HW-1:0]   st_hz_one;
  logic [HW-1:0]   st_hz_two;
  logic [MW-1:0]   st_mv_one;
  logic [MW-1:0]   st_mv_two;
  logic [CW-1:0]   st_pct;
  logic            st_follow;

  // Sample stage outputs
  logic [SW-1:0] sample_one;
  logic [SW-1:0] sample_two;

  // Advance each stage when the next one is empty or moving
  always_comb begin
    ready_out = !m_tvalid || m_tready;
    ready_two = !st_valid || ready_out;
    s_tready  = !in_valid || ready_two;
    accept    = s_tvalid && s_tready;
  end

  // Hold the vertical offset
  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_offset <= '0;
    end else if (cfg_we) begin
      vertical_offset <= cfg_wdata;
    end
  end

  dcwg_knobs #(
    .AMP_STEPS   (AMP_STEPS),
    .FREQ_STEPS  (FREQ_STEPS),
    .DELAY_STEPS (DELAY_STEPS)
  ) u_knobs (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (accept && s_tuser),
    .channel   (s_tdata[CH_LSB]),
    .knob      (s_tdata[KNOB_LSB +: dcwg_pkg::KNOB_W]),
    .direction (s_tdata[DIR_LSB]),
    .kind      (kind),
    .amp       (amp),
    .freq      (freq),
    .delay     (delay),
    .follow    (follow)
  );

  // Input register: valid flag and phase index
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_phase <= s_tdata[PHASE_LSB +: dcwg_pkg::PHASE_W];
    end
  end

  dcwg_addr #(
    .LUT_DEPTH   (LUT_DEPTH),
    .AMP_STEPS   (AMP_STEPS),
    .FREQ_STEPS  (FREQ_STEPS),
    .DELAY_STEPS (DELAY_STEPS),
    .MAX_FREQ_HZ (MAX_FREQ_HZ)
  ) u_addr (
    .phase    (in_phase),
    .kind     (kind),
    .amp      (amp),
    .freq     (freq),
    .delay    (delay),
    .follow   (follow),
    .addr_one (a_addr_one),
    .addr_two (a_addr_two),
    .kind_two (a_kind_two),
    .amul_one (a_amul_one),
    .amul_two (a_amul_two),
    .hz_one   (a_hz_one),
    .hz_two   (a_hz_two),
    .mv_one   (a_mv_one),
    .mv_two   (a_mv_two),
    .pct      (a_pct)
  );

  // Address register; knob state here already includes the item's event
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (ready_two) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_two && in_valid) begin
      st_addr_one <= a_addr_one;
      st_addr_two <= a_addr_two;
      st_kind_one <= kind[0];
      st_kind_two <= a_kind_two;
      st_amul_one <= a_amul_one;
      st_amul_two <= a_amul_two;
      st_hz_one   <= a_hz_one;
      st_hz_two   <= a_hz_two;
      st_mv_one   <= a_mv_one;
      st_mv_two   <= a_mv_two;
      st_pct      <= a_pct;
      st_follow   <= follow;
    end
  end

  dcwg_voice #(
    .AMP_STEPS (AMP_STEPS)
  ) u_voice_one (
    .addr   (st_addr_one),
    .kind   (st_kind_one),
    .amul   (st_amul_one),
    .offset (vertical_offset),
    .sample (sample_one)
  );

  dcwg_voice #(
    .AMP_STEPS (AMP_STEPS)
  ) u_voice_two (
    .addr   (st_addr_two),
    .kind   (st_kind_two),
    .amul   (st_amul_two),
    .offset (vertical_offset),
    .sample (sample_two)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready_out) begin
      m_tvalid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && st_valid) begin
      m_tdata <= {st_follow, st_pct, st_kind_two, st_kind_one, st_mv_two, st_mv_one,
                  st_hz_two, st_hz_one, sample_two, sample_one};
    end
  end

  `DCWG_CHECK_IMPLY(a_empty_out_takes_input, !m_tvalid, s_tready, "input blocked with empty output")
  `DCWG_CHECK_IMPLY(a_out_from_stage, $rose(m_tvalid), $past(st_valid), "result without a staged item")
  `DCWG_CHECK(a_stage_holds, (st_valid && m_tvalid && !m_tready) |=> (st_valid && $stable(st_addr_one) && $stable(st_amul_two)), "stalled stage lost its item")

endmodule

>>> hw/rtl/dcwg_knobs.sv
// Knob state of both channels: wave type, amplitude and frequency steps,
// follow delay and follow flag. Depends on dcwg_pkg and the assertion header.
`include "dual_channel_wave_table_generator_top_assert.svh"

module dcwg_knobs #(
  parameter int AMP_STEPS   = dcwg_pkg::AMP_STEPS_DEF,
  parameter int FREQ_STEPS  = dcwg_pkg::FREQ_STEPS_DEF,
  parameter int DELAY_STEPS = dcwg_pkg::DELAY_STEPS_DEF,
  localparam int AW = $clog2(AMP_STEPS + 1),
  localparam int FW = $clog2(FREQ_STEPS + 1),
  localparam int DW = $clog2(DELAY_STEPS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ev_valid,
  input  logic                          channel,
  input  logic [dcwg_pkg::KNOB_W-1:0]   knob,
  input  logic                          direction,
  output dcwg_pkg::wave_t               kind   [2],
  output logic [AW-1:0]                 amp    [2],
  output logic [FW-1:0]                 freq   [2],
  output logic [DW-1:0]                 delay,
  output logic                          follow
);

  dcwg_pkg::wave_t kind_next [2];
  logic [AW-1:0]   amp_next  [2];
  logic [FW-1:0]   freq_next [2];
  logic [DW-1:0]   delay_next;
  logic            follow_next;

  // Apply one knob event; steps wrap at both ends
  always_comb begin
    kind_next   = kind;
    amp_next    = amp;
    freq_next   = freq;
    delay_next  = delay;
    follow_next = follow;
    if (ev_valid) begin
      unique case (dcwg_pkg::knob_t'(knob))
        dcwg_pkg::KNOB_TYPE: begin
          case (kind[channel])
            dcwg_pkg::WAVE_SINE:   kind_next[channel] = dcwg_pkg::WAVE_SQUARE;
            dcwg_pkg::WAVE_SQUARE: kind_next[channel] = dcwg_pkg::WAVE_PULSE;
            default:               kind_next[channel] = dcwg_pkg::WAVE_SINE;
          endcase
        end
        dcwg_pkg::KNOB_AMP: begin
          if (direction) begin
            amp_next[channel] = (amp[channel] >= AW'(AMP_STEPS)) ? AW'(1)
                              : amp[channel] + AW'(1);
          end else begin
            amp_next[channel] = (amp[channel] <= AW'(1)) ? AW'(AMP_STEPS)
                              : amp[channel] - AW'(1);
          end
        end
        dcwg_pkg::KNOB_FREQ: begin
          if (direction) begin
            freq_next[channel] = (freq[channel] >= FW'(FREQ_STEPS)) ? FW'(1)
                               : freq[channel] + FW'(1);
          end else begin
            freq_next[channel] = (freq[channel] <= FW'(1)) ? FW'(FREQ_STEPS)
                               : freq[channel] - FW'(1);
          end
        end
        dcwg_pkg::KNOB_FOLLOW: begin
          follow_next = direction;
        end
        dcwg_pkg::KNOB_DELAY: begin
          if (direction) begin
            delay_next = (delay >= DW'(DELAY_STEPS)) ? DW'(1) : delay + DW'(1);
          end else begin
            delay_next = (delay <= DW'(1)) ? DW'(DELAY_STEPS) : delay - DW'(1);
          end
        end
        default: begin
          // unused knob codes change nothing
        end
      endcase
    end
  end

  // Hold the knob state
  always_ff @(posedge clk) begin
    if (rst) begin
      kind[0] <= dcwg_pkg::WAVE_SINE;
      kind[1] <= dcwg_pkg::WAVE_SINE;
      amp[0]  <= AW'(1);
      amp[1]  <= AW'(1);
      freq[0] <= FW'(1);
      freq[1] <= FW'(1);
      delay   <= DW'(DELAY_STEPS);
      follow  <= 1'b0;
    end else begin
      kind   <= kind_next;
      amp    <= amp_next;
      freq   <= freq_next;
      delay  <= delay_next;
      follow <= follow_next;
    end
  end

  `DCWG_CHECK(a_delay_range, delay != '0 && delay <= DW'(DELAY_STEPS), "delay step out of range")
  `DCWG_CHECK(a_amp_range, amp[0] != '0 && amp[1] != '0 && amp[0] <= AW'(AMP_STEPS) && amp[1] <= AW'(AMP_STEPS), "amplitude step out of range")
  `DCWG_CHECK(a_tick_keeps_state, !ev_valid |=> ($stable(follow) && $stable(delay)), "state moved without a knob event")

endmodule

>>> hw/rtl/dcwg_addr.sv
// Address and settings stage: ROM addresses of both channels, follow
// selection and the table lookups of scale, Hz, mV and percent. Uses dcwg_pkg.
module dcwg_addr #(
  parameter int LUT_DEPTH   = dcwg_pkg::LUT_DEPTH_DEF,
  parameter int AMP_STEPS   = dcwg_pkg::AMP_STEPS_DEF,
  parameter int FREQ_STEPS  = dcwg_pkg::FREQ_STEPS_DEF,
  parameter int DELAY_STEPS = dcwg_pkg::DELAY_STEPS_DEF,
  parameter int MAX_FREQ_HZ = dcwg_pkg::MAX_FREQ_HZ_DEF,
  localparam int AW = $clog2(AMP_STEPS + 1),
  localparam int FW = $clog2(FREQ_STEPS + 1),
  localparam int DW = $clog2(DELAY_STEPS + 1),
  localparam longint unsigned AM_RECIP =
    ((64'd1 << dcwg_pkg::AMP_FRAC) + AMP_STEPS - 1) / AMP_STEPS,
  localparam int MULW = $clog2(AMP_STEPS * AM_RECIP + 1)
) (
  input  logic [dcwg_pkg::PHASE_W-1:0] phase,
  input  dcwg_pkg::wave_t              kind      [2],
  input  logic [AW-1:0]                amp       [2],
  input  logic [FW-1:0]                freq      [2],
  input  logic [DW-1:0]                delay,
  input  logic                         follow,
  output logic [dcwg_pkg::ROM_AW-1:0]  addr_one,
  output logic [dcwg_pkg::ROM_AW-1:0]  addr_two,
  output dcwg_pkg::wave_t              kind_two,
  output logic [MULW-1:0]              amul_one,
  output logic [MULW-1:0]              amul_two,
  output logic [dcwg_pkg::FREQ_W-1:0]  hz_one,
  output logic [dcwg_pkg::FREQ_W-1:0]  hz_two,
  output logic [dcwg_pkg::MV_W-1:0]    mv_one,
  output logic [dcwg_pkg::MV_W-1:0]    mv_two,
  output logic [dcwg_pkg::PCT_W-1:0]   pct
);

  localparam int PW  = $clog2(LUT_DEPTH);
  localparam int SW  = PW + 1;
  localparam int NPH = 1 << dcwg_pkg::PHASE_W;
  localparam int RA  = dcwg_pkg::ROM_AW;
  localparam longint unsigned ADDR_RECIP =
    ((64'd1 << dcwg_pkg::ADDR_FRAC) + LUT_DEPTH - 1) / LUT_DEPTH;
  localparam int MPW = $clog2(ADDR_RECIP + 1);
  localparam int PRW = PW + MPW;
  localparam int HW  = dcwg_pkg::FREQ_W;
  localparam int MW  = dcwg_pkg::MV_W;
  localparam int CW  = dcwg_pkg::PCT_W;

  // Table position of each phase index
  function automatic logic [NPH*PW-1:0] build_pos();
    logic [NPH*PW-1:0] t;
    t = '0;
    for (int i = 0; i < NPH; i++) t[i*PW +: PW] = PW'(i % LUT_DEPTH);
    return t;
  endfunction

  // ROM address of each phase index, no shift
  function automatic logic [NPH*RA-1:0] build_raddr();
    logic [NPH*RA-1:0] t;
    t = '0;
    for (int i = 0; i < NPH; i++) begin
      t[i*RA +: RA] = RA'(((i % LUT_DEPTH) * dcwg_pkg::ROM_SIZE) / LUT_DEPTH);
    end
    return t;
  endfunction

  // Follower shift in table positions for each delay step
  function automatic logic [(DELAY_STEPS+1)*SW-1:0] build_shift();
    logic [(DELAY_STEPS+1)*SW-1:0] t;
    t = '0;
    for (int d = 0; d <= DELAY_STEPS; d++) begin
      t[d*SW +: SW] = SW'((longint'(d) * LUT_DEPTH) / DELAY_STEPS);
    end
    return t;
  endfunction

  // Delay in percent of a period
  function automatic logic [(DELAY_STEPS+1)*CW-1:0] build_pct();
    logic [(DELAY_STEPS+1)*CW-1:0] t;
    t = '0;
    for (int d = 0; d <= DELAY_STEPS; d++) begin
      t[d*CW +: CW] = CW'((d * dcwg_pkg::PCT_FULL) / DELAY_STEPS);
    end
    return t;
  endfunction

  // Amplitude scale factor: step over step count, in AMP_FRAC fraction bits
  function automatic logic [(AMP_STEPS+1)*MULW-1:0] build_amul();
    logic [(AMP_STEPS+1)*MULW-1:0] t;
    t = '0;
    for (int a = 0; a <= AMP_STEPS; a++) t[a*MULW +: MULW] = MULW'(a * AM_RECIP);
    return t;
  endfunction

  // Amplitude in millivolts
  function automatic logic [(AMP_STEPS+1)*MW-1:0] build_mv();
    logic [(AMP_STEPS+1)*MW-1:0] t;
    longint v;
    t = '0;
    for (int a = 0; a <= AMP_STEPS; a++) begin
      v = (longint'(a) * dcwg_pkg::FULL_MV) / AMP_STEPS;
      if (v > dcwg_pkg::MV_MAX) v = dcwg_pkg::MV_MAX;
      t[a*MW +: MW] = MW'(v);
    end
    return t;
  endfunction

  // Frequency in hertz; the lowest step is always 1 Hz
  function automatic logic [(FREQ_STEPS+1)*HW-1:0] build_hz();
    logic [(FREQ_STEPS+1)*HW-1:0] t;
    longint v;
    t = '0;
    for (int f = 0; f <= FREQ_STEPS; f++) begin
      v = (longint'(f) * MAX_FREQ_HZ) / FREQ_STEPS;
      if (f == 1) v = 1;
      if (v > dcwg_pkg::FREQ_MAX_OUT) v = dcwg_pkg::FREQ_MAX_OUT;
      t[f*HW +: HW] = HW'(v);
    end
    return t;
  endfunction

  localparam logic [NPH*PW-1:0]                 POS_TAB   = build_pos();
  localparam logic [NPH*RA-1:0]                 RADDR_TAB = build_raddr();
  localparam logic [(DELAY_STEPS+1)*SW-1:0]     SHIFT_TAB = build_shift();
  localparam logic [(DELAY_STEPS+1)*CW-1:0]     PCT_TAB   = build_pct();
  localparam logic [(AMP_STEPS+1)*MULW-1:0]     AMUL_TAB  = build_amul();
  localparam logic [(AMP_STEPS+1)*MW-1:0]       MV_TAB    = build_mv();
  localparam logic [(FREQ_STEPS+1)*HW-1:0]      HZ_TAB    = build_hz();

  logic [PW-1:0]  pos_one;
  logic [SW-1:0]  shift;
  logic [SW-1:0]  pos_sum;
  logic [PW-1:0]  pos_lag;
  logic [PRW-1:0] addr_prod;
  logic [AW-1:0]  amp_sel;
  logic [FW-1:0]  freq_sel;

  // Shift the follower position and wrap it once
  always_comb begin
    pos_one   = POS_TAB[phase*PW +: PW];
    shift     = SHIFT_TAB[delay*SW +: SW];
    pos_sum   = SW'(pos_one) + shift;
    pos_lag   = (pos_sum >= SW'(LUT_DEPTH)) ? PW'(pos_sum - SW'(LUT_DEPTH)) : PW'(pos_sum);
    addr_prod = PRW'(pos_lag) * PRW'(ADDR_RECIP);
  end

  // Pick channel two's settings: its own, or channel one's when following
  always_comb begin
    addr_one = RADDR_TAB[phase*RA +: RA];
    addr_two = follow ? addr_prod[dcwg_pkg::ADDR_FRAC-RA +: RA] : addr_one;
    kind_two = follow ? kind[0] : kind[1];
    amp_sel  = follow ? amp[0]  : amp[1];
    freq_sel = follow ? freq[0] : freq[1];
  end

  // Look up scale, display values and delay percent
  always_comb begin
    amul_one = AMUL_TAB[amp[0]*MULW +: MULW];
    amul_two = AMUL_TAB[amp_sel*MULW +: MULW];
    mv_one   = MV_TAB[amp[0]*MW +: MW];
    mv_two   = MV_TAB[amp_sel*MW +: MW];
    hz_one   = HZ_TAB[freq[0]*HW +: HW];
    hz_two   = HZ_TAB[freq_sel*HW +: HW];
    pct      = PCT_TAB[delay*CW +: CW];
  end

endmodule

>>> hw/rtl/dcwg_voice.sv
// Sample stage of one channel: wave ROM read, amplitude scale, offset and
// saturation. Uses the sine ROM and constants of dcwg_pkg.
module dcwg_voice #(
  parameter int AMP_STEPS = dcwg_pkg::AMP_STEPS_DEF,
  localparam longint unsigned AM_RECIP =
    ((64'd1 << dcwg_pkg::AMP_FRAC) + AMP_STEPS - 1) / AMP_STEPS,
  localparam int MULW = $clog2(AMP_STEPS * AM_RECIP + 1)
) (
  input  logic [dcwg_pkg::ROM_AW-1:0]   addr,
  input  dcwg_pkg::wave_t               kind,
  input  logic [MULW-1:0]               amul,
  input  logic [dcwg_pkg::OFFSET_W-1:0] offset,
  output logic [dcwg_pkg::SAMPLE_W-1:0] sample
);

  localparam int SW  = dcwg_pkg::SAMPLE_W;
  localparam int PRW = SW + MULW;
  localparam int RA  = dcwg_pkg::ROM_AW;

  logic [SW-1:0]  wave;
  logic [PRW-1:0] prod;
  logic [SW-1:0]  scaled;
  logic [SW:0]    sum;

  // Read the wave shape at the ROM address
  always_comb begin
    case (kind)
      dcwg_pkg::WAVE_SQUARE:
        wave = (addr < RA'(dcwg_pkg::SQUARE_HIGH)) ? SW'(dcwg_pkg::WAVE_PEAK) : '0;
      dcwg_pkg::WAVE_PULSE:
        wave = (addr < RA'(dcwg_pkg::PULSE_HIGH)) ? SW'(dcwg_pkg::WAVE_PEAK) : '0;
      default:
        wave = dcwg_pkg::SINE_ROM[addr];
    endcase
  end

  // Scale by the reciprocal factor, add the offset, clamp at full scale
  always_comb begin
    prod   = PRW'(wave) * PRW'(amul);
    scaled = prod[dcwg_pkg::AMP_FRAC +: SW];
    sum    = {1'b0, scaled} + {1'b0, offset};
    sample = sum[SW] ? SW'(dcwg_pkg::SAMPLE_MAX) : sum[SW-1:0];
  end

endmodule
